// File: src/assert_macros.svh
// Assertion macros used by the checker in bdlp_chk.sv.
// Expects clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is high.
`define BDLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset.
`define BDLP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long-press detection.
// No dependencies.
package bdlp_pkg;

  localparam int NUM_THRESH     = 4;
  localparam int MAX_LONG_PRESS = 4;
  localparam int CNT_W          = 3;
  localparam int IDX_W          = 3;
  localparam int DATA_W         = 32;
  localparam int TIME_W         = 32;
  localparam int DEB_W          = 16;

  // Effective upper bound on the number of thresholds in use
  localparam logic [CNT_W-1:0] CNT_LIMIT =
    CNT_W'((MAX_LONG_PRESS < NUM_THRESH) ? MAX_LONG_PRESS : NUM_THRESH);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_ACTIVE_LOW  = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE_MS = 3'd1;
  localparam logic [IDX_W-1:0] REG_LP_COUNT    = 3'd2;
  localparam logic [IDX_W-1:0] REG_LP_MS_0     = 3'd3;
  localparam logic [IDX_W-1:0] REG_LP_MS_1     = 3'd4;
  localparam logic [IDX_W-1:0] REG_LP_MS_2     = 3'd5;
  localparam logic [IDX_W-1:0] REG_LP_MS_3     = 3'd6;

  typedef struct packed {
    logic                                active_low;
    logic [DEB_W-1:0]                    settle_ms;
    logic [CNT_W-1:0]                    long_press_count;
    logic [NUM_THRESH-1:0][TIME_W-1:0]   long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic                  press_event;
    logic [NUM_THRESH-1:0] long_fired_mask;
    logic                  pressed;
    logic                  stable_level;
  } result_t;

endpackage

// File: src/bdlp_cfg.sv
// Configuration register file for the debouncer.
// Depends on bdlp_pkg.
module bdlp_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bdlp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::DATA_W-1:0]  cfg_data,
  output bdlp_pkg::cfg_t               cfg
);
  import bdlp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low       <= 1'b1;
      cfg.settle_ms        <= 16'd50;
      cfg.long_press_count <= '0;
      cfg.long_press_ms[0] <= 32'd1000;
      cfg.long_press_ms[1] <= 32'd2000;
      cfg.long_press_ms[2] <= 32'd3000;
      cfg.long_press_ms[3] <= 32'd5000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_LOW:  cfg.active_low       <= cfg_data[0];
        REG_DEBOUNCE_MS: cfg.settle_ms        <= cfg_data[DEB_W-1:0];
        REG_LP_COUNT:    cfg.long_press_count <= cfg_data[CNT_W-1:0];
        REG_LP_MS_0:     cfg.long_press_ms[0] <= cfg_data[TIME_W-1:0];
        REG_LP_MS_1:     cfg.long_press_ms[1] <= cfg_data[TIME_W-1:0];
        REG_LP_MS_2:     cfg.long_press_ms[2] <= cfg_data[TIME_W-1:0];
        REG_LP_MS_3:     cfg.long_press_ms[3] <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/bdlp_core.sv
// Debounce and long-press state with its one-pass update logic.
// Depends on bdlp_pkg.
module bdlp_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         raw,
  input  logic [bdlp_pkg::TIME_W-1:0]  now,
  input  bdlp_pkg::cfg_t               cfg,
  output bdlp_pkg::result_t            res
);
  import bdlp_pkg::*;

  logic                  last_raw, last_raw_next;
  logic [TIME_W-1:0]     raw_change_time, raw_change_time_next;
  logic                  debounced_level, debounced_level_next;
  logic                  pressed_flag, pressed_flag_next;
  logic [TIME_W-1:0]     press_start_time, press_start_time_next;
  logic [NUM_THRESH-1:0] fired_flags, fired_flags_next;

  logic [TIME_W-1:0]     since_change;
  logic [TIME_W-1:0]     held_old;
  logic [TIME_W-1:0]     held;
  logic [CNT_W-1:0]      count_sat;
  logic                  settled;
  logic                  press_begin;
  logic [NUM_THRESH-1:0] fire;
  logic [NUM_THRESH-1:0] fired_base;

  always_comb begin
    count_sat = (cfg.long_press_count > CNT_LIMIT) ? CNT_LIMIT : cfg.long_press_count;

    last_raw_next        = raw;
    raw_change_time_next = (raw != last_raw) ? now : raw_change_time;
    since_change         = now - raw_change_time_next;
    held_old             = now - press_start_time;

    settled = (since_change >= {{(TIME_W-DEB_W){1'b0}}, cfg.settle_ms}) &&
              (debounced_level != raw);
    press_begin = settled && (raw == ~cfg.active_low);

    debounced_level_next  = settled ? raw : debounced_level;
    pressed_flag_next     = settled ? press_begin : pressed_flag;
    press_start_time_next = press_begin ? now : press_start_time;
    fired_base            = press_begin ? '0 : fired_flags;
    // A press that starts now has zero held time
    held                  = press_begin ? '0 : held_old;

    for (int i = 0; i < NUM_THRESH; i++) begin
      fire[i] = pressed_flag_next && (CNT_W'(i) < count_sat) && !fired_base[i] &&
                (held >= cfg.long_press_ms[i]);
    end
    fired_flags_next = fired_base | fire;

    res.press_event     = press_begin;
    res.long_fired_mask = fire;
    res.pressed         = pressed_flag_next;
    res.stable_level    = debounced_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw         <= 1'b1;
      raw_change_time  <= '0;
      debounced_level  <= 1'b1;
      pressed_flag     <= 1'b0;
      press_start_time <= '0;
      fired_flags      <= '0;
    end else if (step) begin
      last_raw         <= last_raw_next;
      raw_change_time  <= raw_change_time_next;
      debounced_level  <= debounced_level_next;
      pressed_flag     <= pressed_flag_next;
      press_start_time <= press_start_time_next;
      fired_flags      <= fired_flags_next;
    end
  end

endmodule

// File: src/button_debounce_long_press_top.sv
// Button debouncer with long-press detection, one poll per transfer.
// Path: a poll waits in the input register, then its result is loaded into the result register.
// Throughput: one poll per cycle while out_stall is low; the state update is a single combinational pass.
// Reset (rst, synchronous, active high): both registers empty, raw and stable level high,
// not pressed, fired flags clear, configuration back to its defaults.
// Depends on bdlp_pkg, bdlp_cfg and bdlp_core.
module button_debounce_long_press_top (
  input  logic                                clk,
  input  logic                                rst,
  // poll input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                raw_level,
  input  logic [bdlp_pkg::TIME_W-1:0]         now_ms,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [bdlp_pkg::IDX_W-1:0]          cfg_index,
  input  logic [bdlp_pkg::DATA_W-1:0]         cfg_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                press_event,
  output logic [bdlp_pkg::NUM_THRESH-1:0]     long_fired_mask,
  output logic                                pressed,
  output logic                                stable_level
);
  import bdlp_pkg::*;

  // Input register: one poll waiting for the state update
  logic              in_full;
  logic              raw_q;
  logic [TIME_W-1:0] now_q;

  // Result register
  result_t           res_q;
  result_t           res_comb;

  cfg_t              cfg;
  logic              in_take;
  logic              advance;

  // Move the held poll through the update when the result register is free
  // or is being drained this cycle.
  assign advance  = in_full && (!out_valid || !out_stall);
  // Stall only when the input register holds a poll that cannot move on.
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // State commits exactly when the poll's result is captured.
  bdlp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .raw  (raw_q),
    .now  (now_q),
    .cfg  (cfg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // Payload of the input register: load on every transfer.
  always_ff @(posedge clk) begin
    if (in_take) begin
      raw_q <= raw_level;
      now_q <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result while stalled; load a new one on each advance.
  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign press_event     = res_q.press_event;
  assign long_fired_mask = res_q.long_fired_mask;
  assign pressed         = res_q.pressed;
  assign stable_level    = res_q.stable_level;

endmodule

// File: src/bdlp_chk.sv
// Port-level checks for the debouncer top level, attached by bind.
// Depends on bdlp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bdlp_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            press_event,
  input logic [bdlp_pkg::NUM_THRESH-1:0] long_fired_mask,
  input logic                            pressed
);
  import bdlp_pkg::*;

  // A stalled result holds valid and payload.
  property p_out_hold;
    out_valid && out_stall |=>
      out_valid && $stable(press_event) && $stable(long_fired_mask) && $stable(pressed);
  endproperty

  `BDLP_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result valid right after reset")
  `BDLP_ASSERT(a_out_hold, p_out_hold, "stalled result changed")
  `BDLP_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "stall with result free")
  `BDLP_ASSERT(a_event_pressed, out_valid && press_event |-> pressed, "event while released")
  `BDLP_ASSERT(a_fire_pressed, out_valid && (long_fired_mask != '0) |-> pressed, "fired released")

endmodule

bind button_debounce_long_press_top bdlp_chk u_bdlp_chk (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .press_event     (press_event),
  .long_fired_mask (long_fired_mask),
  .pressed         (pressed)
);

// File: sim/button_debounce_long_press_top_tb.sv
// Self-checking testbench for button_debounce_long_press_top: directed polls, then
// randomized press/hold/release episodes under several register settings.
// Depends on bdlp_pkg and the RTL of the block.
module button_debounce_long_press_top_tb;
  import bdlp_pkg::*;

  // Index with no register behind it; writes there must be dropped.
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int NUM_PHASES = 8;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  raw_level;
  logic [TIME_W-1:0]     now_ms;
  logic                  cfg_we;
  logic [IDX_W-1:0]      cfg_index;
  logic [DATA_W-1:0]     cfg_data;
  logic                  out_valid;
  logic                  out_stall;
  logic                  press_event;
  logic [NUM_THRESH-1:0] long_fired_mask;
  logic                  pressed;
  logic                  stable_level;

  button_debounce_long_press_top DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .raw_level       (raw_level),
    .now_ms          (now_ms),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .press_event     (press_event),
    .long_fired_mask (long_fired_mask),
    .pressed         (pressed),
    .stable_level    (stable_level)
  );

  // Register shadow, kept in step with every write the testbench makes.
  logic              pol_low = 1'b1;
  logic [DEB_W-1:0]  deb_ms = 16'd50;
  logic [CNT_W-1:0]  lp_count = '0;
  logic [TIME_W-1:0] lp_ms [NUM_THRESH] = '{32'd1000, 32'd2000, 32'd3000, 32'd5000};

  // Debouncer state as the block should hold it.
  logic                  pin_last = 1'b1;
  logic [TIME_W-1:0]     pin_change_ms = '0;
  logic                  level_stable = 1'b1;
  logic                  held_down = 1'b0;
  logic [TIME_W-1:0]     press_begin_ms = '0;
  logic [NUM_THRESH-1:0] lp_fired = '0;

  result_t pending_polls [$];   // expected results, oldest first
  int      fail_count = 0;
  int      sent_count = 0;
  int      gap_pct = 0;         // chance of an idle gap before a poll
  int      stall_pct = 0;       // chance of the receiver starting a stall
  int      stall_left = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run one poll through the shadow state and return what the block should report.
  function automatic result_t debounce_poll(input logic raw, input logic [TIME_W-1:0] now);
    result_t     r;
    logic        press_lvl;
    logic [TIME_W-1:0] held;
    int          n_used;
    r = '0;
    press_lvl = ~pol_low;
    n_used = (lp_count > CNT_LIMIT) ? int'(CNT_LIMIT) : int'(lp_count);
    if (raw != pin_last) begin
      pin_last = raw;
      pin_change_ms = now;
    end
    if ((now - pin_change_ms) >= {16'd0, deb_ms} && level_stable != pin_last) begin
      level_stable = pin_last;
      if (level_stable == press_lvl) begin
        held_down = 1'b1;
        press_begin_ms = now;
        lp_fired = '0;
        r.press_event = 1'b1;
      end else begin
        held_down = 1'b0;
      end
    end
    if (held_down) begin
      held = now - press_begin_ms;
      for (int i = 0; i < n_used; i++) begin
        if (!lp_fired[i] && held >= lp_ms[i]) begin
          lp_fired[i] = 1'b1;
          r.long_fired_mask[i] = 1'b1;
        end
      end
    end
    r.pressed = held_down;
    r.stable_level = level_stable;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Present one poll at the falling edge and hold it until the block takes it.
  task automatic send_poll(input logic raw, input logic [TIME_W-1:0] now);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    raw_level = raw;
    now_ms = now;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_polls.insert(pending_polls.size(), debounce_poll(raw, now));
    sent_count++;
  endtask

  // Advance the poll clock by delta and send the level at that time.
  task automatic step(input logic raw, input logic [TIME_W-1:0] delta);
    clock_ms = clock_ms + delta;
    send_poll(raw, clock_ms);
  endtask

  // Drop valid and wait until every expected result is out and the pipe is empty.
  task automatic settle_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_polls.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ACTIVE_LOW:  pol_low = data[0];
      REG_DEBOUNCE_MS: deb_ms = data[DEB_W-1:0];
      REG_LP_COUNT:    lp_count = data[CNT_W-1:0];
      REG_LP_MS_0:     lp_ms[0] = data;
      REG_LP_MS_1:     lp_ms[1] = data;
      REG_LP_MS_2:     lp_ms[2] = data;
      REG_LP_MS_3:     lp_ms[3] = data;
      default: ;
    endcase
  endtask

  // Defaults after reset: 50 ms debounce, no thresholds; release crosses the 32-bit wrap.
  task automatic test_debounce_defaults();
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'd10);
    send_poll(1'b0, 32'd59);
    send_poll(1'b0, 32'd60);
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'd49);
  endtask

  // Zero debounce and a ladder of thresholds, including zero and the largest hold time.
  task automatic test_threshold_ladder();
    settle_idle();
    write_reg(REG_DEBOUNCE_MS, 32'd0);
    write_reg(REG_LP_COUNT, 32'd4);
    write_reg(REG_LP_MS_0, 32'd0);
    write_reg(REG_LP_MS_1, 32'd5);
    write_reg(REG_LP_MS_2, 32'd10);
    write_reg(REG_LP_MS_3, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'd100);
    send_poll(1'b0, 32'd105);
    send_poll(1'b0, 32'd110);
    send_poll(1'b0, 32'd111);
    send_poll(1'b0, 32'd99);   // held time wraps to all ones
    send_poll(1'b1, 32'd200);
  endtask

  // A count above the number of thresholds saturates; a smaller count masks the rest.
  task automatic test_count_saturation();
    settle_idle();
    write_reg(REG_LP_COUNT, 32'd7);
    write_reg(REG_LP_MS_0, 32'd1);
    write_reg(REG_LP_MS_1, 32'd1);
    write_reg(REG_LP_MS_2, 32'd1);
    write_reg(REG_LP_MS_3, 32'd1);
    send_poll(1'b0, 32'd300);
    send_poll(1'b0, 32'd301);
    send_poll(1'b1, 32'd302);
    settle_idle();
    write_reg(REG_LP_COUNT, 32'd2);
    send_poll(1'b0, 32'd400);
    send_poll(1'b0, 32'd401);
    send_poll(1'b1, 32'd402);
  endtask

  // Flip polarity while held: pressed status holds until the next stable change.
  task automatic test_polarity_swap();
    settle_idle();
    write_reg(REG_DEBOUNCE_MS, 32'd5);
    write_reg(REG_LP_COUNT, 32'd1);
    write_reg(REG_LP_MS_0, 32'd3);
    send_poll(1'b0, 32'd1000);
    send_poll(1'b0, 32'd1005);
    settle_idle();
    write_reg(REG_ACTIVE_LOW, 32'd0);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'd1010);
    send_poll(1'b1, 32'd1011);
    send_poll(1'b1, 32'd1016);
    send_poll(1'b0, 32'd1017);
    send_poll(1'b0, 32'd1022);
  endtask

  // Bounce a few times, then settle on target long enough to be accepted (or nearly).
  task automatic bounce_to(input logic target);
    int n;
    n = $urandom_range(0, 3);
    repeat (n) step(1'($urandom_range(0, 1)), $urandom_range(0, deb_ms));
    step(target, $urandom_range(0, 2));
    if (deb_ms != 0 && $urandom_range(0, 4) == 0) begin
      step(target, deb_ms - 1);
      step(target, $urandom_range(1, 2));
    end else begin
      step(target, deb_ms + $urandom_range(0, 3));
    end
  endtask

  // One full press: bounce in, hold across thresholds with glitches, bounce out.
  task automatic press_episode();
    logic press_lvl;
    int   n;
    int   k;
    press_lvl = ~pol_low;
    bounce_to(press_lvl);
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          // aim one poll just before, at, or just after a threshold
          k = $urandom_range(0, NUM_THRESH - 1);
          clock_ms = press_begin_ms + lp_ms[k] + $urandom_range(0, 2) - 32'd1;
          send_poll(press_lvl, clock_ms);
        end
        2: begin
          step(~press_lvl, $urandom_range(0, 3));
          step(press_lvl, $urandom_range(0, 3));
        end
        default: step(press_lvl, $urandom_range(0, 60));
      endcase
    end
    bounce_to(~press_lvl);
  endtask

  // Random pin levels at random times.
  task automatic noise_burst();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) begin
      clock_ms = $urandom;
      send_poll(1'($urandom_range(0, 1)), clock_ms);
    end
  endtask

  function automatic logic [TIME_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  task automatic set_phase_config(input int phase);
    logic [DATA_W-1:0] data;
    logic [DEB_W-1:0]  deb;
    logic [CNT_W-1:0]  cnt;
    case (phase)
      0: deb = '0;
      1: deb = '1;
      default: deb = DEB_W'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 20));
    endcase
    case (phase)
      2: cnt = '0;
      4: cnt = '1;
      default: cnt = CNT_W'($urandom_range(0, 7));
    endcase
    // upper bits of the write data are junk on purpose: only the register width counts
    data = $urandom;
    data[0] = phase[0];
    write_reg(REG_ACTIVE_LOW, data);
    data = $urandom;
    data[DEB_W-1:0] = deb;
    write_reg(REG_DEBOUNCE_MS, data);
    data = $urandom;
    data[CNT_W-1:0] = cnt;
    write_reg(REG_LP_COUNT, data);
    write_reg(REG_LP_MS_0, pick_threshold());
    write_reg(REG_LP_MS_1, pick_threshold());
    write_reg(REG_LP_MS_2, pick_threshold());
    write_reg(REG_LP_MS_3, pick_threshold());
    if ($urandom_range(0, 1)) write_reg(REG_UNMAPPED, $urandom);
  endtask

  task automatic test_random_phases();
    int  phase_end;
    int  half;
    bit  paused;
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_idle();
      set_phase_config(p);
      // one phase runs flat out on both sides; the rest idle at random
      gap_pct = (p == 3) ? 0 : $urandom_range(15, 40);
      stall_pct = (p == 3) ? 0 : $urandom_range(15, 40);
      clock_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 : $urandom;
      phase_end = sent_count + ITEMS_PER_PHASE;
      half = sent_count + ITEMS_PER_PHASE / 2;
      paused = 1'b0;
      while (sent_count < phase_end) begin
        if (p == 5 && !paused && sent_count >= half) begin
          settle_idle();   // hold off the sender until the pipe is empty
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) noise_burst();
        else press_episode();
      end
    end
    gap_pct = 0;
    stall_pct = 0;
  endtask

  // Receiver back-pressure, driven at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall = 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_polls.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        fail_count++;
      end else begin
        want = pending_polls.pop_front();
        if (press_event !== want.press_event) begin
          $display("%0t: press_event expected %b got %b", $time, want.press_event, press_event);
          fail_count++;
        end
        if (long_fired_mask !== want.long_fired_mask) begin
          $display("%0t: long_fired_mask expected %h got %h", $time,
                   want.long_fired_mask, long_fired_mask);
          fail_count++;
        end
        if (pressed !== want.pressed) begin
          $display("%0t: pressed expected %b got %b", $time, want.pressed, pressed);
          fail_count++;
        end
        if (stable_level !== want.stable_level) begin
          $display("%0t: stable_level expected %b got %b", $time,
                   want.stable_level, stable_level);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    raw_level = 1'b1;
    now_ms = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_debounce_defaults();
    test_threshold_ladder();
    test_count_saturation();
    test_polarity_swap();
    test_random_phases();
    settle_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_polls.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/bdlp_pkg.sv
src/bdlp_cfg.sv
src/bdlp_core.sv
src/button_debounce_long_press_top.sv
src/bdlp_chk.sv
sim/button_debounce_long_press_top_tb.sv
